// ===== rtl/core/ufdx_pkg.sv =====
// Shared types and constants for the UART frame deframer with XOR check.
// No dependencies; imported by every module of the block.
package ufdx_pkg;

   localparam logic [7:0]  SOF_CHECKED       = 8'hFE;
   localparam logic [7:0]  SOF_UNCHECKED     = 8'hFF;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1018;
   localparam logic [7:0]  IDLE_TICKS_RESET  = 8'd3;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // word index of the control registers (byte address bit 2)
   localparam logic CSR_MAX_PAYLOAD = 1'b0;
   localparam logic CSR_IDLE_TICKS  = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_CMD_HI  = 3'd3,
      PH_CMD_LO  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_TRAILER = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_FCS  = 2'd2,
      KIND_DROP = 2'd3
   } kind_type;

   typedef struct packed {
      logic        emit;
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  command_high;
      logic [7:0]  command_low;
      logic [15:0] payload_len;
      logic        was_checked;
      logic        frame_end;
   } result_type;

endpackage

// ===== rtl/core/uart_frame_deframer_xor_unit.sv =====
// Top level of the UART frame deframer with XOR check: control registers,
// result register and handshake. Uses ufdx_pkg and ufdx_frame_fsm.
//
// The block takes one received byte or tick per clock cycle and gives its
// result, if any, in the result register in the cycle after the transfer. The
// frame state is updated in the same cycle the item is taken, so a new item
// is accepted every cycle as long as the result register is empty or is
// being emptied in that cycle; a stalled result holds the input side only.
// Registers: max_payload at byte address 0, idle_ticks at byte address 4;
// writes take effect for the next item.
module uart_frame_deframer_xor_unit
   import ufdx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_command_high,
   output logic [7:0]  rsp_command_low,
   output logic [15:0] rsp_payload_len,
   output logic        rsp_was_checked,
   output logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] max_payload_ff;
   logic [7:0]  idle_ticks_ff;
   logic        csr_write;
   logic        accept;
   result_type  step_result;
   result_type  rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         idle_ticks_ff  <= IDLE_TICKS_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_MAX_PAYLOAD) begin
            max_payload_ff <= csr_pwdata[15:0];
         end else begin
            idle_ticks_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_IDLE_TICKS) begin
         csr_prdata = {24'h000000, idle_ticks_ff};
      end else begin
         csr_prdata = {16'h0000, max_payload_ff};
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   ufdx_frame_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (accept),
      .step_mode   (req_mode),
      .step_byte   (req_rx_byte),
      .max_payload (max_payload_ff),
      .idle_ticks  (idle_ticks_ff),
      .result      (step_result)
   );

   always_comb begin
      if (accept && step_result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_result.emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_command_high = rsp_ff.command_high;
   assign rsp_command_low  = rsp_ff.command_low;
   assign rsp_payload_len  = rsp_ff.payload_len;
   assign rsp_was_checked  = rsp_ff.was_checked;
   assign rsp_frame_end    = rsp_ff.frame_end;

endmodule

// ===== rtl/core/ufdx_frame_fsm.sv =====
// Frame state machine: hunts for start bytes, tracks length, command,
// payload and trailer, and forms at most one result per transfer. Uses ufdx_pkg.
module ufdx_frame_fsm
   import ufdx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_valid,
   input  logic        step_mode,
   input  logic [7:0]  step_byte,
   input  logic [15:0] max_payload,
   input  logic [7:0]  idle_ticks,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic        checked_ff, checked_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  cmd_hi_ff, cmd_hi_in;
   logic [7:0]  cmd_lo_ff, cmd_lo_in;
   logic [7:0]  idle_ff, idle_in;
   logic [15:0] seen_inc;
   logic        is_sof;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         checked_ff <= 1'b0;
         length_ff  <= '0;
         seen_ff    <= '0;
         xor_ff     <= '0;
         cmd_hi_ff  <= '0;
         cmd_lo_ff  <= '0;
         idle_ff    <= '0;
      end else if (step_valid) begin
         phase_ff   <= phase_in;
         checked_ff <= checked_in;
         length_ff  <= length_in;
         seen_ff    <= seen_in;
         xor_ff     <= xor_in;
         cmd_hi_ff  <= cmd_hi_in;
         cmd_lo_ff  <= cmd_lo_in;
         idle_ff    <= idle_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      checked_in = checked_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      xor_in     = xor_ff;
      cmd_hi_in  = cmd_hi_ff;
      cmd_lo_in  = cmd_lo_ff;
      idle_in    = idle_ff;
      seen_inc   = seen_ff + 16'd1;
      is_sof     = (step_byte == SOF_CHECKED) || (step_byte == SOF_UNCHECKED);

      result.emit         = 1'b0;
      result.kind         = KIND_DATA;
      result.payload_byte = '0;
      result.frame_end    = 1'b0;

      if (step_mode == MODE_TICK) begin
         if (phase_ff != PH_HUNT) begin
            if (idle_ff != 8'd0) begin
               idle_in = idle_ff - 8'd1;
            end else begin
               result.emit      = 1'b1;
               result.kind      = KIND_DROP;
               result.frame_end = 1'b1;
               phase_in         = PH_HUNT;
            end
         end
      end else begin
         if (phase_ff != PH_HUNT) begin
            idle_in = idle_ticks;
         end
         case (phase_ff)
            PH_HUNT: begin
               if (is_sof) begin
                  checked_in = (step_byte == SOF_CHECKED);
                  length_in  = '0;
                  seen_in    = '0;
                  xor_in     = '0;
                  cmd_hi_in  = '0;
                  cmd_lo_in  = '0;
                  idle_in    = idle_ticks;
                  phase_in   = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               length_in = {step_byte, 8'h00};
               xor_in    = xor_ff ^ step_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = length_ff | {8'h00, step_byte};
               xor_in    = xor_ff ^ step_byte;
               if (length_in > max_payload) begin
                  result.emit      = 1'b1;
                  result.kind      = KIND_DROP;
                  result.frame_end = 1'b1;
                  phase_in         = PH_HUNT;
               end else begin
                  phase_in = PH_CMD_HI;
               end
            end
            PH_CMD_HI: begin
               cmd_hi_in = step_byte;
               xor_in    = xor_ff ^ step_byte;
               phase_in  = PH_CMD_LO;
            end
            PH_CMD_LO: begin
               cmd_lo_in = step_byte;
               xor_in    = xor_ff ^ step_byte;
               phase_in  = (length_ff == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               xor_in  = xor_ff ^ step_byte;
               seen_in = seen_inc;
               if (seen_inc >= length_ff) begin
                  phase_in = PH_TRAILER;
               end
               result.emit         = 1'b1;
               result.kind         = KIND_DATA;
               result.payload_byte = step_byte;
            end
            PH_TRAILER: begin
               result.emit      = 1'b1;
               result.frame_end = 1'b1;
               if (checked_ff && (step_byte != xor_ff)) begin
                  result.kind = KIND_FCS;
               end else begin
                  result.kind = KIND_GOOD;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end

      result.command_high = cmd_hi_in;
      result.command_low  = cmd_lo_in;
      result.payload_len  = length_in;
      result.was_checked  = checked_in;
   end

endmodule

// ===== rtl/core/ufdx_checker.sv =====
// Port-level checks for uart_frame_deframer_xor_unit, attached by bind.
// Uses ufdx_pkg for the result kind codes.
module ufdx_port_checks
   import ufdx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_frame_end
);

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_DATA) != rsp_frame_end))
      else $error("frame end does not match result kind");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_byte)))
      else $error("stalled result changed");

endmodule

bind uart_frame_deframer_xor_unit ufdx_port_checks u_ufdx_port_checks (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_end    (rsp_frame_end)
);
